// ===== src/go_back_n_sender_assert.svh =====
// Assertion macros for the checker file of the go-back-n sender.
// No dependencies; included by name where assertions are written.
`ifndef GO_BACK_N_SENDER_ASSERT_SVH
`define GO_BACK_N_SENDER_ASSERT_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define GBN_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error(msg);

// Same, on the usual clk / rst_n pair.
`define GBN_ASSERT(label, prop, msg) `GBN_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

// ===== src/gbn_pkg.sv =====
// Shared types and constants for the go-back-n sender.
// No dependencies; used by go_back_n_sender and gbn_checker.
`default_nettype none

package gbn_pkg;

    // parameter defaults
    localparam int PAYLOAD_BYTES_DEF = 253;
    localparam int SEQ_SPACE_DEF     = 256;
    localparam int TIME_WIDTH_DEF    = 32;

    // fixed field widths
    localparam int BYTE_W      = 8;
    localparam int FILL_W      = 8;
    localparam int LEN32_W     = 32;
    localparam int OFF_W       = 33;   // byte offset, one bit of headroom past the last packet
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [BYTE_W-1:0] ACK_TYPE = 8'h03;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_START = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE    = 2'd0,
        REG_TIMEOUT_TICKS  = 2'd1,
        REG_MESSAGE_LENGTH = 2'd2
    } cfg_reg_t;

    localparam logic [7:0]  WINDOW_SIZE_RST   = 8'd1;
    localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd5000;

endpackage

`default_nettype wire

// ===== src/go_back_n_sender.sv =====
// Go-back-n sender: input register, one pass of window logic, result register.
// The input transfer is held in the input register, the result in the result register;
// one item per cycle sustained while the result stream is not stalled. The rate rests
// on the window update and on the send time memory, read ahead at the next base seq.
// Reset (rst_n, async low) clears window, counters and config to defaults;
// send time memory holds no reset value.
// Depends on gbn_pkg.
`default_nettype none

module go_back_n_sender #(
    parameter int PAYLOAD_BYTES = gbn_pkg::PAYLOAD_BYTES_DEF,
    parameter int SEQ_SPACE     = gbn_pkg::SEQ_SPACE_DEF,
    parameter int TIME_WIDTH    = gbn_pkg::TIME_WIDTH_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // config write port
    input  wire                              cfg_we,
    input  wire [gbn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [gbn_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [gbn_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // frame_check, frame_type, frame_seq
    input  wire [1:0]                        s_axis_tuser,  // cmd
    // result stream
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // send_valid, send_seq, send_offset, send_length, outstanding, timed_out,
    // frame_accepted, done_res, zero pad
    output logic [gbn_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast   // send_last
);

    localparam int SW  = $clog2(SEQ_SPACE);
    localparam int SW1 = SW + 1;
    localparam int CW  = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
    localparam int OW  = gbn_pkg::OFF_W;
    localparam int FW  = gbn_pkg::FILL_W;
    localparam int BW  = gbn_pkg::BYTE_W;
    localparam int OTW = gbn_pkg::OUT_TDATA_W;

    // config
    logic [7:0]             window_size_reg;
    logic [31:0]            timeout_ticks_reg;
    logic [31:0]            message_length_reg;

    // sender state
    logic [TIME_WIDTH-1:0]  time_reg, time_next;
    logic [SW-1:0]          base_reg, base_next;
    logic [SW-1:0]          seq_reg, seq_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [OW-1:0]          issue_off_reg, issue_off_next;
    logic [OW-1:0]          acked_off_reg, acked_off_next;
    logic [31:0]            xfer_len_reg, xfer_len_next;
    logic [TIME_WIDTH-1:0]  oldest_reg;

    logic [TIME_WIDTH-1:0]  send_time_mem [SEQ_SPACE];

    // input stage
    logic                   in_valid_reg;
    logic [1:0]             in_cmd_reg;
    logic [BW-1:0]          in_check_reg;
    logic [BW-1:0]          in_type_reg;
    logic [BW-1:0]          in_seq_reg;

    // result stage
    logic                   out_valid_reg;
    logic [OTW-1:0]         out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    logic                   proc;
    logic                   in_load;

    // combinational work
    logic                   is_tick, is_frame, is_start, is_event;
    logic [FW-1:0]          win_cap;
    logic                   issue, last_pkt, chk_ok, seq_ok, in_win, ack_ok, tout;
    logic [BW-1:0]          slen;
    logic [FW-1:0]          fill1;
    logic [OW-1:0]          issue_off1;
    logic [SW-1:0]          ack_gap;
    logic [TIME_WIDTH-1:0]  oldest, elapsed;
    logic [SW-1:0]          rd_addr;

    function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] a);
        logic [SW1-1:0] s;
        s = {1'b0, a} + SW1'(1);
        if (s == SW1'(SEQ_SPACE))
            s = '0;
        return s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] seq_sub(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW1-1:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (a < b)
            d = d + SW1'(SEQ_SPACE);
        return d[SW-1:0];
    endfunction

    // ones-complement sum of three bytes must be all ones
    function automatic logic check_sum(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        s = {1'b0, s[7:0]} + {8'd0, s[8]};
        s = {1'b0, s[7:0]} + {1'b0, c};
        s = {1'b0, s[7:0]} + {8'd0, s[8]};
        return s[7:0] == 8'hFF;
    endfunction

    assign proc          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        is_tick  = in_cmd_reg == gbn_pkg::CMD_TICK;
        is_frame = in_cmd_reg == gbn_pkg::CMD_FRAME;
        is_start = in_cmd_reg == gbn_pkg::CMD_START;
        is_event = is_tick || is_frame;

        time_next      = is_tick ? time_reg + TIME_WIDTH'(1) : time_reg;
        base_next      = base_reg;
        seq_next       = seq_reg;
        fill_next      = fill_reg;
        issue_off_next = issue_off_reg;
        acked_off_next = acked_off_reg;
        xfer_len_next  = xfer_len_reg;

        win_cap = (window_size_reg > 8'(SEQ_SPACE - 1)) ? 8'(SEQ_SPACE - 1) : window_size_reg;

        // issue one descriptor if room and packets remain
        issue    = is_event && (fill_reg < win_cap) && (issue_off_reg < {1'b0, xfer_len_reg});
        last_pkt = (issue_off_reg + OW'(PAYLOAD_BYTES)) >= {1'b0, xfer_len_reg};
        slen     = last_pkt ? BW'(message_length_reg - issue_off_reg[31:0]) : BW'(PAYLOAD_BYTES);
        fill1      = issue ? fill_reg + FW'(1) : fill_reg;
        issue_off1 = issue ? issue_off_reg + OW'(PAYLOAD_BYTES) : issue_off_reg;
        if (issue)
            seq_next = seq_inc(seq_reg);

        // acknowledgement: window is the fill1 entries from base
        chk_ok  = check_sum(in_check_reg, in_type_reg, in_seq_reg);
        seq_ok  = {1'b0, in_seq_reg} < 9'(SEQ_SPACE);
        ack_gap = seq_sub(in_seq_reg[SW-1:0], base_reg);
        in_win  = seq_ok && (FW'(ack_gap) < fill1);
        ack_ok  = is_frame && (in_type_reg == gbn_pkg::ACK_TYPE) && chk_ok && in_win;

        // oldest send time; window was empty before issue -> stamped just now
        oldest  = (fill_reg == '0) ? time_next : oldest_reg;
        elapsed = time_next - oldest;
        tout    = is_event && !ack_ok && (fill1 != '0) &&
                  (CW'(elapsed) > CW'(timeout_ticks_reg));

        fill_next      = fill1;
        issue_off_next = issue_off1;
        if (ack_ok)
        begin
            base_next      = seq_inc(in_seq_reg[SW-1:0]);
            fill_next      = fill1 - FW'(ack_gap) - FW'(1);
            acked_off_next = acked_off_reg +
                             OW'(OW'(FW'(ack_gap) + 9'd1) * OW'(PAYLOAD_BYTES));
        end
        else if (tout)
        begin
            seq_next       = base_reg;
            issue_off_next = issue_off1 - OW'(OW'(fill1) * OW'(PAYLOAD_BYTES));
            fill_next      = '0;
        end

        if (is_start)
        begin
            xfer_len_next  = message_length_reg;
            issue_off_next = '0;
            acked_off_next = '0;
            seq_next       = base_reg;
            fill_next      = '0;
        end

        rd_addr = proc ? base_next : base_reg;

        out_data_next = '0;
        out_data_next[0]     = issue;
        out_data_next[8:1]   = issue ? BW'(seq_reg) : '0;
        out_data_next[40:9]  = issue ? issue_off_reg[31:0] : '0;
        out_data_next[48:41] = issue ? slen : '0;
        out_data_next[56:49] = fill_next;
        out_data_next[57]    = tout;
        out_data_next[58]    = ack_ok;
        out_data_next[59]    = acked_off_next >= {1'b0, xfer_len_next};
        out_last_next        = issue && last_pkt;
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg    <= gbn_pkg::WINDOW_SIZE_RST;
            timeout_ticks_reg  <= gbn_pkg::TIMEOUT_TICKS_RST;
            message_length_reg <= '0;
            time_reg           <= '0;
            base_reg           <= '0;
            seq_reg            <= '0;
            fill_reg           <= '0;
            issue_off_reg      <= '0;
            acked_off_reg      <= '0;
            xfer_len_reg       <= '0;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gbn_pkg::REG_WINDOW_SIZE:    window_size_reg    <= cfg_data[7:0];
                    gbn_pkg::REG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_data;
                    gbn_pkg::REG_MESSAGE_LENGTH: message_length_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (proc)
            begin
                time_reg      <= time_next;
                base_reg      <= base_next;
                seq_reg       <= seq_next;
                fill_reg      <= fill_next;
                issue_off_reg <= issue_off_next;
                acked_off_reg <= acked_off_next;
                xfer_len_reg  <= xfer_len_next;
            end

            if (in_load)
                in_valid_reg <= 1'b1;
            else if (proc)
                in_valid_reg <= 1'b0;

            if (proc)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_cmd_reg   <= s_axis_tuser;
            in_check_reg <= s_axis_tdata[7:0];
            in_type_reg  <= s_axis_tdata[15:8];
            in_seq_reg   <= s_axis_tdata[23:16];
        end
        if (proc)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    // send time memory; read ahead at the next base into oldest_reg, write-first
    always_ff @(posedge clk)
    begin
        if (proc && issue)
            send_time_mem[seq_reg] <= time_next;
        if (proc && issue && (seq_reg == rd_addr))
            oldest_reg <= time_next;
        else
            oldest_reg <= send_time_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/gbn_checker.sv =====
// Port-level checks on the go-back-n sender result stream, bound to the top level.
// Depends on gbn_pkg and go_back_n_sender_assert.svh.
`default_nettype none

`include "go_back_n_sender_assert.svh"

module gbn_checker #(
    parameter int PAYLOAD_BYTES = gbn_pkg::PAYLOAD_BYTES_DEF
) (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [gbn_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input wire                              m_axis_tlast
);

    // no descriptor -> descriptor fields and last flag are zero
    `GBN_ASSERT(a_desc_clear, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[48:1] == '0 && !m_axis_tlast, "descriptor fields set without send_valid")

    // issued packet carries a payload no longer than one packet
    `GBN_ASSERT(a_len_range, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[48:41] != 8'd0 && m_axis_tdata[48:41] <= 8'(PAYLOAD_BYTES), "send_length out of range")

    // go-back empties the window and never coincides with an ack
    `GBN_ASSERT(a_goback_flush, m_axis_tvalid && m_axis_tdata[57] |-> m_axis_tdata[56:49] == 8'd0 && !m_axis_tdata[58], "timeout without window flush")

    // stalled result holds
    `GBN_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

endmodule

bind go_back_n_sender gbn_checker #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
) u_gbn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
